// ----- sv/loc_pkg.sv -----
// Shared types and constants for the line orientation classifier.
package loc_pkg;

  localparam int PRE_SHIFT    = 40;
  localparam int CORDIC_STEPS = 32;

  localparam logic [31:0] HALF_TURN32    = 32'h8000_0000;
  localparam logic [31:0] QUARTER_TURN32 = 32'h4000_0000;

  localparam logic [31:0] ATAN_TURN32 [CORDIC_STEPS] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
    32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
    32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
    32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
  };

  localparam logic [1:0] REG_ROLL = 2'd0;
  localparam logic [1:0] REG_HTOL = 2'd1;
  localparam logic [1:0] REG_VTOL = 2'd2;

  localparam logic [1:0] CLASS_NONE  = 2'd0;
  localparam logic [1:0] CLASS_HORIZ = 2'd1;
  localparam logic [1:0] CLASS_VERT  = 2'd2;

  localparam int unsigned HTOL_RESET = 1820;
  localparam int unsigned VTOL_RESET = 910;

  typedef struct packed {
    logic dx_neg;
    logic dy_neg;
    logic ax_zero;
    logic ay_zero;
  } loc_ctrl_t;

endpackage

// ----- sv/loc_prep.sv -----
// Input stage: endpoint differences, magnitudes and quadrant flags.
module loc_prep import loc_pkg::*; #(
  parameter int CW = 12
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    valid_i,
  input  logic [CW-1:0]           x_start_i,
  input  logic [CW-1:0]           y_start_i,
  input  logic [CW-1:0]           x_end_i,
  input  logic [CW-1:0]           y_end_i,
  output logic                    valid_o,
  output loc_ctrl_t               ctrl_o,
  output logic signed [CW+PRE_SHIFT+2:0] x_o,
  output logic signed [CW+PRE_SHIFT+2:0] y_o,
  output logic [4*CW-1:0]         coords_o
);

  localparam int XW = CW + PRE_SHIFT + 3;

  logic signed [CW:0] dx, dy;
  logic [CW-1:0]      ax, ay;
  logic               valid_q;
  loc_ctrl_t          ctrl_d, ctrl_q;
  logic signed [XW-1:0] x_d, x_q, y_d, y_q;
  logic [4*CW-1:0]    coords_q;

  assign dx = $signed({1'b0, x_start_i}) - $signed({1'b0, x_end_i});
  assign dy = $signed({1'b0, y_start_i}) - $signed({1'b0, y_end_i});
  assign ax = dx[CW] ? CW'(-dx) : CW'(dx);
  assign ay = dy[CW] ? CW'(-dy) : CW'(dy);

  assign ctrl_d.dx_neg  = dx[CW];
  assign ctrl_d.dy_neg  = dy[CW];
  assign ctrl_d.ax_zero = (ax == '0);
  assign ctrl_d.ay_zero = (ay == '0);

  assign x_d = $signed({{(XW-CW-PRE_SHIFT){1'b0}}, ax, {PRE_SHIFT{1'b0}}});
  assign y_d = $signed({{(XW-CW-PRE_SHIFT){1'b0}}, ay, {PRE_SHIFT{1'b0}}});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    ctrl_q   <= ctrl_d;
    x_q      <= x_d;
    y_q      <= y_d;
    coords_q <= {x_start_i, y_start_i, x_end_i, y_end_i};
  end

  assign valid_o  = valid_q;
  assign ctrl_o   = ctrl_q;
  assign x_o      = x_q;
  assign y_o      = y_q;
  assign coords_o = coords_q;

endmodule

// ----- sv/loc_cordic_stage.sv -----
// One registered vectoring CORDIC iteration.
module loc_cordic_stage import loc_pkg::*; #(
  parameter int CW   = 12,
  parameter int STEP = 0
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    valid_i,
  input  loc_ctrl_t               ctrl_i,
  input  logic signed [CW+PRE_SHIFT+2:0] x_i,
  input  logic signed [CW+PRE_SHIFT+2:0] y_i,
  input  logic [31:0]             z_i,
  input  logic [4*CW-1:0]         coords_i,
  output logic                    valid_o,
  output loc_ctrl_t               ctrl_o,
  output logic signed [CW+PRE_SHIFT+2:0] x_o,
  output logic signed [CW+PRE_SHIFT+2:0] y_o,
  output logic [31:0]             z_o,
  output logic [4*CW-1:0]         coords_o
);

  localparam int XW = CW + PRE_SHIFT + 3;
  localparam logic [31:0] ATAN = ATAN_TURN32[STEP];

  logic              y_neg;
  logic [XW-1:0]     xs, ymag, ys;
  logic signed [XW-1:0] x_d, x_q, y_d, y_q;
  logic [31:0]       z_d, z_q;
  logic              valid_q;
  loc_ctrl_t         ctrl_q;
  logic [4*CW-1:0]   coords_q;

  assign y_neg = y_i[XW-1];
  assign xs    = $unsigned(x_i) >> STEP;
  assign ymag  = y_neg ? $unsigned(-y_i) : $unsigned(y_i);
  assign ys    = ymag >> STEP;

  assign y_d = y_neg ? (y_i + $signed(xs)) : (y_i - $signed(xs));
  assign x_d = x_i + $signed(ys);
  assign z_d = y_neg ? (z_i - ATAN) : (z_i + ATAN);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    ctrl_q   <= ctrl_i;
    x_q      <= x_d;
    y_q      <= y_d;
    z_q      <= z_d;
    coords_q <= coords_i;
  end

  assign valid_o  = valid_q;
  assign ctrl_o   = ctrl_q;
  assign x_o      = x_q;
  assign y_o      = y_q;
  assign z_o      = z_q;
  assign coords_o = coords_q;

endmodule

// ----- sv/loc_angle.sv -----
// Quadrant restore and rounding of the CORDIC angle to binary angle units.
module loc_angle import loc_pkg::*; #(
  parameter int CW = 12,
  parameter int AW = 16
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  input  loc_ctrl_t       ctrl_i,
  input  logic [31:0]     z_i,
  input  logic [4*CW-1:0] coords_i,
  output logic            valid_o,
  output logic [AW-1:0]   angle_o,
  output logic [4*CW-1:0] coords_o
);

  localparam int SH = 32 - AW;

  logic [31:0]     theta, full;
  logic [AW-1:0]   angle_d, angle_q;
  logic            valid_q;
  logic [4*CW-1:0] coords_q;

  always_comb begin
    if (ctrl_i.ay_zero) begin
      theta = '0;
    end else if (ctrl_i.ax_zero) begin
      theta = QUARTER_TURN32;
    end else begin
      theta = z_i;
    end
    unique case ({ctrl_i.dx_neg, ctrl_i.dy_neg})
      2'b00:   full = theta;
      2'b01:   full = 32'd0 - theta;
      2'b10:   full = HALF_TURN32 - theta;
      default: full = theta - HALF_TURN32;
    endcase
  end

  assign angle_d = full[31:SH] + AW'(full[SH-1]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    angle_q  <= angle_d;
    coords_q <= coords_i;
  end

  assign valid_o  = valid_q;
  assign angle_o  = angle_q;
  assign coords_o = coords_q;

endmodule

// ----- sv/loc_match.sv -----
// Wrapped angle differences against the roll references and the class decision.
module loc_match import loc_pkg::*; #(
  parameter int CW = 12,
  parameter int AW = 16
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  input  logic [AW-1:0]   angle_i,
  input  logic [4*CW-1:0] coords_i,
  input  logic [AW-1:0]   roll_i,
  input  logic [AW-2:0]   htol_i,
  input  logic [AW-2:0]   vtol_i,
  output logic            done_o,
  output logic [1:0]      class_o,
  output logic [4*CW-1:0] coords_o
);

  localparam logic [AW-1:0] HALF    = {1'b1, {(AW-1){1'b0}}};
  localparam logic [AW-1:0] QUARTER = {2'b01, {(AW-2){1'b0}}};

  logic [AW-1:0]   vref, dh_raw, dv_raw, dh_d, dv_d, dh_q, dv_q;
  logic [AW-1:0]   htol, vtol;
  logic            h_hit, v_hit;
  logic [1:0]      class_d, class_q;
  logic            valid_q, done_q;
  logic [4*CW-1:0] coords_q, out_coords_q;

  assign vref   = roll_i + QUARTER;
  assign dh_raw = angle_i - roll_i;
  assign dv_raw = angle_i - vref;
  assign dh_d   = (dh_raw > HALF) ? (AW'(0) - dh_raw) : dh_raw;
  assign dv_d   = (dv_raw > HALF) ? (AW'(0) - dv_raw) : dv_raw;

  assign htol  = {1'b0, htol_i};
  assign vtol  = {1'b0, vtol_i};
  assign h_hit = (dh_q < htol) || (dh_q > (HALF - htol));
  assign v_hit = (dv_q < vtol) || (dv_q > (HALF - vtol));

  always_comb begin
    priority if (h_hit) begin
      class_d = CLASS_HORIZ;
    end else if (v_hit) begin
      class_d = CLASS_VERT;
    end else begin
      class_d = CLASS_NONE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      valid_q <= valid_i;
      done_q  <= valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    dh_q         <= dh_d;
    dv_q         <= dv_d;
    coords_q     <= coords_i;
    class_q      <= class_d;
    out_coords_q <= coords_q;
  end

  assign done_o   = done_q;
  assign class_o  = class_q;
  assign coords_o = out_coords_q;

endmodule

// ----- sv/line_orientation_classifier.sv -----
// Top level of the line orientation classifier.
//
// A segment transaction is taken at each rising edge where start is high
// and busy is low; busy is always low, so one segment can enter every
// clock cycle with no gaps.
// Each segment produces exactly one result transaction: done_o is high for
// one cycle together with line_class_o and the four endpoints passed through.
// Each segment passes through the registered input preparation, the 32-step
// unrolled CORDIC, one iteration per register stage, angle rounding and the
// two-stage tolerance compare before its result appears.
// Results leave in the order segments arrived, one per cycle at most.
// The receiver cannot stall the block and must take each result when shown.
// Configuration writes (roll, horizontal and vertical tolerance) take effect
// on the next edge and should be made while no segment is in flight.
// Reset clears all in-flight transactions and loads roll 0 and the default
// tolerances; the block is ready in the first cycle after reset.
module line_orientation_classifier import loc_pkg::*; #(
  parameter int COORD_WIDTH = 12,
  parameter int ANGLE_WIDTH = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start,
  output logic                   busy,
  input  logic [COORD_WIDTH-1:0] x_start_i,
  input  logic [COORD_WIDTH-1:0] y_start_i,
  input  logic [COORD_WIDTH-1:0] x_end_i,
  input  logic [COORD_WIDTH-1:0] y_end_i,
  output logic                   done_o,
  output logic [1:0]             line_class_o,
  output logic [COORD_WIDTH-1:0] out_x_start_o,
  output logic [COORD_WIDTH-1:0] out_y_start_o,
  output logic [COORD_WIDTH-1:0] out_x_end_o,
  output logic [COORD_WIDTH-1:0] out_y_end_o,
  input  logic                   cfg_we_i,
  input  logic [1:0]             cfg_idx_i,
  input  logic [ANGLE_WIDTH-1:0] cfg_wdata_i
);

  localparam int CW = COORD_WIDTH;
  localparam int AW = ANGLE_WIDTH;
  localparam int XW = CW + PRE_SHIFT + 3;

  logic [AW-1:0] roll_q;
  logic [AW-2:0] htol_q, vtol_q;

  logic                 valid_w  [CORDIC_STEPS+1];
  loc_ctrl_t            ctrl_w   [CORDIC_STEPS+1];
  logic signed [XW-1:0] x_w      [CORDIC_STEPS+1];
  logic signed [XW-1:0] y_w      [CORDIC_STEPS+1];
  logic [31:0]          z_w      [CORDIC_STEPS+1];
  logic [4*CW-1:0]      coords_w [CORDIC_STEPS+1];

  logic            ang_valid;
  logic [AW-1:0]   ang;
  logic [4*CW-1:0] ang_coords, out_coords;

  assign busy = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      roll_q <= '0;
      htol_q <= (AW-1)'(HTOL_RESET);
      vtol_q <= (AW-1)'(VTOL_RESET);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_ROLL: roll_q <= cfg_wdata_i;
        REG_HTOL: htol_q <= cfg_wdata_i[AW-2:0];
        REG_VTOL: vtol_q <= cfg_wdata_i[AW-2:0];
        default:  roll_q <= roll_q;
      endcase
    end
  end

  loc_prep #(.CW(CW)) u_prep (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (start && !busy),
    .x_start_i (x_start_i),
    .y_start_i (y_start_i),
    .x_end_i   (x_end_i),
    .y_end_i   (y_end_i),
    .valid_o   (valid_w[0]),
    .ctrl_o    (ctrl_w[0]),
    .x_o       (x_w[0]),
    .y_o       (y_w[0]),
    .coords_o  (coords_w[0])
  );

  assign z_w[0] = '0;

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
    loc_cordic_stage #(.CW(CW), .STEP(i)) u_stage (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .valid_i  (valid_w[i]),
      .ctrl_i   (ctrl_w[i]),
      .x_i      (x_w[i]),
      .y_i      (y_w[i]),
      .z_i      (z_w[i]),
      .coords_i (coords_w[i]),
      .valid_o  (valid_w[i+1]),
      .ctrl_o   (ctrl_w[i+1]),
      .x_o      (x_w[i+1]),
      .y_o      (y_w[i+1]),
      .z_o      (z_w[i+1]),
      .coords_o (coords_w[i+1])
    );
  end

  loc_angle #(.CW(CW), .AW(AW)) u_angle (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (valid_w[CORDIC_STEPS]),
    .ctrl_i   (ctrl_w[CORDIC_STEPS]),
    .z_i      (z_w[CORDIC_STEPS]),
    .coords_i (coords_w[CORDIC_STEPS]),
    .valid_o  (ang_valid),
    .angle_o  (ang),
    .coords_o (ang_coords)
  );

  loc_match #(.CW(CW), .AW(AW)) u_match (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (ang_valid),
    .angle_i  (ang),
    .coords_i (ang_coords),
    .roll_i   (roll_q),
    .htol_i   (htol_q),
    .vtol_i   (vtol_q),
    .done_o   (done_o),
    .class_o  (line_class_o),
    .coords_o (out_coords)
  );

  assign out_x_start_o = out_coords[4*CW-1:3*CW];
  assign out_y_start_o = out_coords[3*CW-1:2*CW];
  assign out_x_end_o   = out_coords[2*CW-1:CW];
  assign out_y_end_o   = out_coords[CW-1:0];

endmodule

// ----- tb/tb_top.sv -----
// Self-checking testbench for the line orientation classifier with its own predictor.
module tb_top import loc_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CW              = 12;
  localparam int AW              = 16;
  localparam int LATENCY         = 35;
  localparam int DRAIN_LIMIT     = 4 * LATENCY + 100;
  localparam int ITEMS_PER_BLOCK = 217;
  localparam int RANDOM_BLOCKS   = 6;
  localparam int IDLE_LIGHT      = 25;
  localparam int IDLE_HEAVY      = 68;
  localparam int IDLE_NONE       = 0;
  localparam int COORD_MAX       = 4095;
  localparam int TOL_MAX         = 16384;
  localparam int HALF_BAU        = 32768;
  localparam int QUARTER_BAU     = 16384;
  localparam int FULL_BAU        = 65536;
  localparam real TIMEOUT_NS     = 2_000_000.0;
  localparam real TWO_PI         = 6.283185307179586;

  localparam logic [31:0] ARCTAN_TABLE [32] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
    32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
    32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
    32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
  };

  typedef struct packed {
    logic [CW-1:0] xs;
    logic [CW-1:0] ys;
    logic [CW-1:0] xe;
    logic [CW-1:0] ye;
  } segment_t;

  typedef struct packed {
    logic [1:0]    line_class;
    logic [CW-1:0] xs;
    logic [CW-1:0] ys;
    logic [CW-1:0] xe;
    logic [CW-1:0] ye;
  } line_result_t;

  logic          clk_i       = 1'b0;
  logic          rst_ni      = 1'b0;
  logic          start       = 1'b0;
  logic          busy;
  logic [CW-1:0] x_start_i   = '0;
  logic [CW-1:0] y_start_i   = '0;
  logic [CW-1:0] x_end_i     = '0;
  logic [CW-1:0] y_end_i     = '0;
  logic          done_o;
  logic [1:0]    line_class_o;
  logic [CW-1:0] out_x_start_o;
  logic [CW-1:0] out_y_start_o;
  logic [CW-1:0] out_x_end_o;
  logic [CW-1:0] out_y_end_o;
  logic          cfg_we_i    = 1'b0;
  logic [1:0]    cfg_idx_i   = REG_ROLL;
  logic [AW-1:0] cfg_wdata_i = '0;

  logic [AW-1:0]   roll_q = '0;
  logic [AW-2:0]   htol_q = 15'(HTOL_RESET);
  logic [AW-2:0]   vtol_q = 15'(VTOL_RESET);
  line_result_t    pending_results [$];
  int              idle_pct    = IDLE_NONE;
  int              error_count = 0;

  line_orientation_classifier #(
    .COORD_WIDTH(CW),
    .ANGLE_WIDTH(AW)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .x_start_i    (x_start_i),
    .y_start_i    (y_start_i),
    .x_end_i      (x_end_i),
    .y_end_i      (y_end_i),
    .done_o       (done_o),
    .line_class_o (line_class_o),
    .out_x_start_o(out_x_start_o),
    .out_y_start_o(out_y_start_o),
    .out_x_end_o  (out_x_end_o),
    .out_y_end_o  (out_y_end_o),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  function automatic logic [31:0] quadrant_angle(logic [31:0] ax, logic [31:0] ay);
    logic [63:0] x;
    logic [63:0] y;
    logic [63:0] xs;
    logic [63:0] ys;
    logic [31:0] z;
    x = {32'd0, ax} << 40;
    y = {32'd0, ay} << 40;
    z = '0;
    for (int i = 0; i < 32; i++) begin
      xs = x >> i;
      if (!y[63]) begin
        ys = y >> i;
        y  = y - xs;
        x  = x + ys;
        z  = z + ARCTAN_TABLE[i];
      end else begin
        ys = (64'd0 - y) >> i;
        y  = y + xs;
        x  = x + ys;
        z  = z - ARCTAN_TABLE[i];
      end
    end
    return z;
  endfunction

  function automatic logic [AW-1:0] segment_angle(int dx, int dy);
    logic [31:0] ax;
    logic [31:0] ay;
    logic [31:0] theta;
    logic [31:0] full;
    logic [31:0] rounded;
    ax = (dx < 0) ? 32'(-dx) : 32'(dx);
    ay = (dy < 0) ? 32'(-dy) : 32'(dy);
    if (ax == 0 && ay == 0) return '0;
    if (ay == 0) theta = '0;
    else if (ax == 0) theta = 32'h4000_0000;
    else theta = quadrant_angle(ax, ay);
    if (dx >= 0) full = (dy >= 0) ? theta : 32'd0 - theta;
    else full = (dy >= 0) ? 32'h8000_0000 - theta : theta - 32'h8000_0000;
    rounded = full + 32'h0000_8000;
    return rounded[31:16];
  endfunction

  function automatic bit within_tolerance(logic [AW-1:0] angle, logic [AW-1:0] base_angle,
                                          logic [AW-2:0] tol);
    logic [AW-1:0] diff;
    int            d;
    diff = angle - base_angle;
    d = int'(diff);
    if (d > HALF_BAU) d = FULL_BAU - d;
    return (d < int'(tol)) || (d > HALF_BAU - int'(tol));
  endfunction

  function automatic line_result_t classify_segment(segment_t s);
    line_result_t  r;
    logic [AW-1:0] angle;
    angle = segment_angle(int'(s.xs) - int'(s.xe), int'(s.ys) - int'(s.ye));
    if (within_tolerance(angle, roll_q, htol_q)) r.line_class = CLASS_HORIZ;
    else if (within_tolerance(angle, roll_q + AW'(QUARTER_BAU), vtol_q)) r.line_class = CLASS_VERT;
    else r.line_class = CLASS_NONE;
    r.xs = s.xs;
    r.ys = s.ys;
    r.xe = s.xe;
    r.ye = s.ye;
    return r;
  endfunction

  function automatic logic [CW-1:0] clamp_coord(int v);
    if (v < 0) return '0;
    if (v > COORD_MAX) return CW'(COORD_MAX);
    return CW'(v);
  endfunction

  function automatic segment_t make_segment(int xs, int ys, int xe, int ye);
    segment_t s;
    s.xs = CW'(xs);
    s.ys = CW'(ys);
    s.xe = CW'(xe);
    s.ye = CW'(ye);
    return s;
  endfunction

  // Aims a segment at a tolerance edge of one of the references, so the
  // compare and the angle rounding are exercised right at their thresholds.
  function automatic segment_t aimed_segment();
    int  base;
    int  tol;
    int  target;
    int  len;
    int  dx;
    int  dy;
    int  xs;
    int  ys;
    real phi;
    if ($urandom_range(0, 1)) begin
      base = int'(roll_q);
      tol  = int'(htol_q);
    end else begin
      base = int'(roll_q) + QUARTER_BAU;
      tol  = int'(vtol_q);
    end
    target = base + ($urandom_range(0, 1) ? tol : -tol) + ($urandom_range(0, 1) ? HALF_BAU : 0)
             + int'($urandom_range(0, 6)) - 3;
    phi = real'(target) * TWO_PI / real'(FULL_BAU);
    len = $urandom_range(200, 2000);
    dx  = $rtoi(real'(len) * $cos(phi));
    dy  = $rtoi(real'(len) * $sin(phi));
    xs  = 2048 + dx / 2;
    ys  = 2048 + dy / 2;
    return make_segment(xs, ys, xs - dx, ys - dy);
  endfunction

  function automatic segment_t random_segment();
    segment_t s;
    int       mode;
    mode = $urandom_range(0, 9);
    s.xs = CW'($urandom_range(0, COORD_MAX));
    s.ys = CW'($urandom_range(0, COORD_MAX));
    s.xe = CW'($urandom_range(0, COORD_MAX));
    s.ye = CW'($urandom_range(0, COORD_MAX));
    case (mode)
      5: begin
        s.xe = clamp_coord(int'(s.xs) + int'($urandom_range(0, 16)) - 8);
        s.ye = clamp_coord(int'(s.ys) + int'($urandom_range(0, 16)) - 8);
      end
      6: begin
        if ($urandom_range(0, 1)) s.ye = s.ys;
        else s.xe = s.xs;
      end
      7: begin
        s.xs = $urandom_range(0, 1) ? CW'(COORD_MAX) : '0;
        s.ys = $urandom_range(0, 1) ? CW'(COORD_MAX) : '0;
        s.xe = $urandom_range(0, 1) ? CW'(COORD_MAX) : '0;
        s.ye = $urandom_range(0, 1) ? CW'(COORD_MAX) : '0;
      end
      8, 9: s = aimed_segment();
      default: ;
    endcase
    return s;
  endfunction

  task automatic report_mismatch(string msg);
    $display("MISMATCH at %0t: %s", $realtime, msg);
    error_count++;
  endtask

  task automatic check_field(string name, int got, int want);
    if (got != want) report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
  endtask

  task automatic send_segment(segment_t s);
    while (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start     <= 1'b1;
    x_start_i <= s.xs;
    y_start_i <= s.ys;
    x_end_i   <= s.xe;
    y_end_i   <= s.ye;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    pending_results.insert(pending_results.size(), classify_segment(s));
  endtask

  task automatic wait_idle();
    int cycles;
    cycles = 0;
    while (pending_results.size() != 0 && cycles < DRAIN_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    if (pending_results.size() != 0) begin
      report_mismatch($sformatf("%0d results never arrived", pending_results.size()));
      pending_results.delete();
    end
  endtask

  task automatic end_batch();
    start <= 1'b0;
    @(posedge clk_i);
    wait_idle();
  endtask

  task automatic write_register(logic [1:0] idx, logic [AW-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    case (idx)
      REG_ROLL: roll_q = data;
      REG_HTOL: htol_q = data[AW-2:0];
      REG_VTOL: vtol_q = data[AW-2:0];
      default: ;
    endcase
  endtask

  task automatic apply_settings(logic [AW-1:0] roll, int unsigned htol, int unsigned vtol);
    write_register(REG_ROLL, roll);
    write_register(REG_HTOL, AW'(htol));
    write_register(REG_VTOL, AW'(vtol));
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic test_reset_defaults();
    idle_pct = IDLE_LIGHT;
    send_segment(make_segment(100, 100, 100, 100));
    send_segment(make_segment(COORD_MAX, 0, 0, 0));
    send_segment(make_segment(0, COORD_MAX, COORD_MAX, COORD_MAX));
    send_segment(make_segment(0, COORD_MAX, 0, 0));
    send_segment(make_segment(COORD_MAX, 0, COORD_MAX, COORD_MAX));
    send_segment(make_segment(COORD_MAX, COORD_MAX, 0, 0));
    send_segment(make_segment(0, COORD_MAX, COORD_MAX, 0));
    send_segment(make_segment(1000, 176, 0, 0));
    send_segment(make_segment(1000, 177, 0, 0));
    send_segment(make_segment(87, 1000, 0, 0));
    send_segment(make_segment(88, 1000, 0, 0));
    send_segment(make_segment(1, 0, 0, 0));
    send_segment(make_segment(0, 1, 0, 0));
    send_segment(make_segment(0, 0, 1, 1));
    end_batch();
  endtask

  task automatic test_tolerance_extremes();
    apply_settings('0, 0, 0);
    send_segment(make_segment(0, 0, COORD_MAX, 0));
    send_segment(make_segment(COORD_MAX, 0, 0, 0));
    send_segment(make_segment(0, COORD_MAX, 0, 0));
    end_batch();
    apply_settings('0, TOL_MAX, TOL_MAX);
    send_segment(make_segment(COORD_MAX, COORD_MAX, 0, 0));
    send_segment(make_segment(0, COORD_MAX, 0, 0));
    send_segment(make_segment(1234, 3210, 2222, 17));
    end_batch();
  endtask

  task automatic test_roll_extremes();
    apply_settings(16'h8000, HTOL_RESET, VTOL_RESET);
    send_segment(make_segment(COORD_MAX, 0, 0, 0));
    send_segment(make_segment(0, 0, 0, COORD_MAX));
    send_segment(make_segment(COORD_MAX, COORD_MAX, 0, 0));
    end_batch();
    apply_settings(16'h7FFF, HTOL_RESET, VTOL_RESET);
    send_segment(make_segment(0, 0, COORD_MAX, 0));
    send_segment(make_segment(0, COORD_MAX, 0, 0));
    send_segment(make_segment(0, 0, 0, COORD_MAX));
    end_batch();
  endtask

  task automatic test_random_segments();
    logic [AW-1:0] roll;
    int unsigned   htol;
    int unsigned   vtol;
    for (int blk = 0; blk < RANDOM_BLOCKS; blk++) begin
      roll = AW'($urandom_range(0, FULL_BAU - 1));
      htol = $urandom_range(0, TOL_MAX);
      vtol = $urandom_range(0, TOL_MAX);
      case (blk)
        0: apply_settings(roll, HTOL_RESET, VTOL_RESET);
        1: apply_settings(roll, htol, vtol);
        2: apply_settings(16'h8000, 0, 0);
        3: apply_settings(16'h7FFF, TOL_MAX, vtol);
        4: apply_settings(roll, htol % 3000, vtol % 3000);
        default: apply_settings('0, HTOL_RESET, VTOL_RESET);
      endcase
      idle_pct = (blk < 2) ? IDLE_LIGHT : (blk < 4) ? IDLE_HEAVY : IDLE_NONE;
      repeat (ITEMS_PER_BLOCK) send_segment(random_segment());
      end_batch();
    end
  endtask

  always @(posedge clk_i) begin : check_results
    line_result_t want;
    if (rst_ni && done_o) begin
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result transaction, class %0d", line_class_o));
      end else begin
        want = pending_results.pop_front();
        check_field("line_class", int'(line_class_o), int'(want.line_class));
        check_field("out_x_start", int'(out_x_start_o), int'(want.xs));
        check_field("out_y_start", int'(out_y_start_o), int'(want.ys));
        check_field("out_x_end", int'(out_x_end_o), int'(want.xe));
        check_field("out_y_end", int'(out_y_end_o), int'(want.ye));
      end
    end
  end

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_defaults();
    test_tolerance_extremes();
    test_roll_extremes();
    test_random_segments();
    wait_idle();
    repeat (LATENCY + 5) @(posedge clk_i);
    if (error_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("TEST FAILED");
    $finish;
  end

endmodule
